// ===== src/imu_velocity_peak_tracker_assert.svh =====
// Assertion macros for the IMU velocity peak tracker checker.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef IMU_VELOCITY_PEAK_TRACKER_ASSERT_SVH
`define IMU_VELOCITY_PEAK_TRACKER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define IVPT_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ivpt check failed");

// Next-cycle implication.
`define IVPT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ivpt check failed");

`endif

// ===== src/ivpt_pkg.sv =====
// Shared widths, register indexes and helper functions of the IMU velocity peak tracker.
// No dependencies.
package ivpt_pkg;

  localparam int unsigned AccelW   = 32;
  localparam int unsigned VelW     = 40;
  localparam int unsigned TimeW    = 48;
  localparam int unsigned FracBits = 16;
  localparam int unsigned DecayW   = 17;
  localparam int unsigned DbW      = 31;
  localparam int unsigned AccW     = 81;
  localparam int unsigned ProdW    = 65;
  localparam int unsigned RadW     = 64;
  localparam int unsigned RootW    = 32;
  localparam int unsigned DivW     = 21;
  localparam int unsigned IncW     = 42;
  localparam int unsigned InW      = 3 * AccelW + TimeW;
  localparam int unsigned OutW     = 3 * RootW + 3 * VelW;

  // 2 * 10^6: trapezoid halving folded into the microsecond scale
  localparam logic [DivW-1:0] UsTwice = 21'd2000000;

  localparam logic [DbW-1:0]    DeadbandRst = 31'd9830;
  localparam logic [DecayW-1:0] DecayRst    = 17'd60293;

  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t CfgBiasX    = 3'd0;
  localparam cfg_idx_t CfgBiasY    = 3'd1;
  localparam cfg_idx_t CfgBiasZ    = 3'd2;
  localparam cfg_idx_t CfgDeadband = 3'd3;
  localparam cfg_idx_t CfgDecay    = 3'd4;

  function automatic logic [AccelW-1:0] abs_acc(input logic signed [AccelW-1:0] v);
    abs_acc = v[AccelW-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [VelW-1:0] abs_vel(input logic signed [VelW-1:0] v);
    abs_vel = v[VelW-1] ? (~v + 1'b1) : v;
  endfunction

  // bias subtract, saturate to 32 bits, then deadband
  function automatic logic signed [AccelW-1:0] correct_axis(
    input logic signed [AccelW-1:0] raw,
    input logic signed [AccelW-1:0] bias,
    input logic [DbW-1:0]           db
  );
    logic signed [AccelW:0]   d;
    logic signed [AccelW-1:0] c;
    d = {raw[AccelW-1], raw} - {bias[AccelW-1], bias};
    if (d[AccelW] != d[AccelW-1]) begin
      c = d[AccelW] ? {1'b1, {(AccelW-1){1'b0}}} : {1'b0, {(AccelW-1){1'b1}}};
    end else begin
      c = d[AccelW-1:0];
    end
    if (abs_acc(c) < {1'b0, db}) c = '0;
    correct_axis = c;
  endfunction

endpackage

// ===== src/ivpt_isqrt.sv =====
// Bit-pair restoring integer square root, one result bit per cycle.
// Depends on ivpt_pkg.
module ivpt_isqrt import ivpt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [RadW-1:0]  radicand_i,
  output logic             done_o,
  output logic [RootW-1:0] root_o
);

  logic            busy_q, busy_d, done_q, done_d;
  logic [RadW-1:0] n_q, n_d, res_q, res_d, bit_q, bit_d;
  logic [RadW:0]   trial;

  always_comb begin
    trial  = {1'b0, res_q} + {1'b0, bit_q};
    n_d    = n_q;
    res_d  = res_q;
    bit_d  = bit_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      n_d    = radicand_i;
      res_d  = '0;
      bit_d  = RadW'(1) << (RadW - 2);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if ({1'b0, n_q} >= trial) begin
        n_d   = n_q - trial[RadW-1:0];
        res_d = (res_q >> 1) + bit_q;
      end else begin
        res_d = res_q >> 1;
      end
      bit_d = bit_q >> 2;
      if (bit_q[0]) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    res_q <= res_d;
    bit_q <= bit_d;
  end

  assign done_o = done_q;
  assign root_o = res_q[RootW-1:0];

endmodule

// ===== src/imu_velocity_peak_tracker.sv =====
// IMU velocity peak tracker: serial multiply-accumulate, reciprocal divide and square root.
// Work per sample: multiply passes for integration and decay, then the 32-step root, used for
//   the acceleration magnitude and, after a time step, for the horizontal speed unless it saturates.
// One sample at a time; input is not ready while a sample is processed.
// The result waits in an output register; the next sample can enter meanwhile.
// Reset: asynchronous active low, clears velocities, history and peaks, restores config defaults.
module imu_velocity_peak_tracker import ivpt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // accel_x[31:0], accel_y[63:32], accel_z[95:64], time_us[143:96]
  input  logic [InW-1:0]   s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  // peak_horizontal_speed[31:0], peak_vertical_speed[63:32], peak_accel[95:64],
  // velocity_x[135:96], velocity_y[175:136], velocity_z[215:176]
  output logic [OutW-1:0]  m_axis_tdata_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  cfg_idx_t         cfg_index_i,
  input  logic [31:0]      cfg_data_i
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_AXIS     = 4'd1;
  localparam logic [3:0] S_MUL      = 4'd2;
  localparam logic [3:0] S_ACC      = 4'd3;
  localparam logic [3:0] S_DIV_INIT = 4'd4;
  localparam logic [3:0] S_DIV      = 4'd5;
  localparam logic [3:0] S_INT_UPD  = 4'd6;
  localparam logic [3:0] S_DEC_UPD  = 4'd7;
  localparam logic [3:0] S_SQ_START = 4'd8;
  localparam logic [3:0] S_SQRT     = 4'd9;
  localparam logic [3:0] S_PEAK_HV  = 4'd10;
  localparam logic [3:0] S_DONE     = 4'd11;

  localparam logic [2:0] J_INT = 3'd0;
  localparam logic [2:0] J_DEC = 3'd1;
  localparam logic [2:0] J_HSQ = 3'd2;
  localparam logic [2:0] J_ASQ = 3'd3;
  localparam logic [2:0] J_RCP = 3'd4;

  // 2e6 = 2^7 * 15625: shift out 2^7, then multiply by the reciprocal of 15625
  localparam int unsigned NumW     = 55;
  localparam int unsigned UsShift  = 7;
  localparam int unsigned RcpSplit = 28;
  localparam int unsigned RcpPost  = 13;
  // ceil(2^69 / 15625), exact floor for numerators below 2^55
  localparam logic [55:0] RcpM = 56'd37778931862957162;

  logic [3:0] st_q, st_d;
  logic [1:0] axis_q, axis_d, pass_q, pass_d;
  logic [2:0] job_q, job_d;

  logic signed [AccelW-1:0] bias_x_q, bias_x_d, bias_y_q, bias_y_d, bias_z_q, bias_z_d;
  logic [DbW-1:0]           deadband_q, deadband_d;
  logic [DecayW-1:0]        decay_q, decay_d;

  logic signed [AccelW-1:0] cx_q, cx_d, cy_q, cy_d, cz_q, cz_d;
  logic signed [AccelW-1:0] lx_q, lx_d, ly_q, ly_d, lz_q, lz_d;
  logic [TimeW-1:0]         last_time_q, last_time_d, dt_q, dt_d;
  logic                     have_prev_q, have_prev_d;
  logic signed [VelW-1:0]   vx_q, vx_d, vy_q, vy_d, vz_q, vz_d;
  logic [RootW-1:0]         max_h_q, max_h_d, max_v_q, max_v_d, max_a_q, max_a_d;

  logic [AccW-1:0]    acc_q, acc_d;
  logic [ProdW-1:0]   prod_q, prod_d;
  logic [NumW-1:0]    num_q, num_d;
  logic [IncW-1:0]    quo_q, quo_d;
  logic [RootW-1:0]   root_q, root_d;

  logic            out_valid_q, out_valid_d;
  logic [OutW-1:0] out_data_q, out_data_d;

  logic             sq_start, sq_done;
  logic [RootW-1:0] sq_root;

  logic signed [AccelW-1:0] in_cx, in_cy, in_cz;
  logic [TimeW-1:0]         in_t;

  logic signed [AccelW-1:0] last_sel, cur_sel;
  logic signed [VelW-1:0]   vel_sel;
  logic [VelW-1:0]          vabs_sel, vabs_x, vabs_y, vabs_z;
  logic signed [AccelW:0]   sum_sel;
  logic [AccelW:0]          m_sel;
  logic [AccelW:0]          mac_a;
  logic [31:0]              mac_b;
  logic [AccW-1:0]          addend;
  logic [AccW-1:0]          acc_base;
  logic [1:0]               pass_last;
  logic signed [VelW+2:0]   vs;
  logic signed [VelW-1:0]   v_int, v_dec;
  logic [VelW:0]            p_dec;
  logic [RootW-1:0]         vz_sat;
  logic                     hs_big;
  logic                     accept;

  assign in_cx = correct_axis(s_axis_tdata_i[AccelW-1:0], bias_x_q, deadband_q);
  assign in_cy = correct_axis(s_axis_tdata_i[2*AccelW-1:AccelW], bias_y_q, deadband_q);
  assign in_cz = correct_axis(s_axis_tdata_i[3*AccelW-1:2*AccelW], bias_z_q, deadband_q);
  assign in_t  = s_axis_tdata_i[InW-1:3*AccelW];

  assign s_axis_tready_o = (st_q == S_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  assign vabs_x = abs_vel(vx_q);
  assign vabs_y = abs_vel(vy_q);
  assign vabs_z = abs_vel(vz_q);
  assign vz_sat = (vabs_z[VelW-1:RootW] != '0) ? '1 : vabs_z[RootW-1:0];
  assign hs_big = (vabs_x[VelW-1:RootW] != '0) || (vabs_y[VelW-1:RootW] != '0);

  // reciprocal product is accumulated low half first, dropping 28 bits twice
  assign acc_base = (job_q == J_RCP && pass_q[0]) ? (acc_q >> RcpSplit) : acc_q;

  // per-axis operand selection
  always_comb begin
    case (axis_q)
      2'd0: begin
        last_sel = lx_q;
        cur_sel  = cx_q;
        vel_sel  = vx_q;
      end
      2'd1: begin
        last_sel = ly_q;
        cur_sel  = cy_q;
        vel_sel  = vy_q;
      end
      default: begin
        last_sel = lz_q;
        cur_sel  = cz_q;
        vel_sel  = vz_q;
      end
    endcase
    sum_sel  = {last_sel[AccelW-1], last_sel} + {cur_sel[AccelW-1], cur_sel};
    m_sel    = sum_sel[AccelW] ? (~sum_sel + 1'b1) : sum_sel;
    vabs_sel = abs_vel(vel_sel);
  end

  // multiplier operands, partial-product shift and pass count per job
  always_comb begin
    mac_a     = '0;
    mac_b     = '0;
    addend    = AccW'(prod_q);
    pass_last = 2'd1;
    case (job_q)
      J_INT: begin
        mac_a     = m_sel;
        pass_last = 2'd2;
        case (pass_q)
          2'd0:    mac_b = {16'd0, dt_q[15:0]};
          2'd1:    mac_b = {16'd0, dt_q[31:16]};
          default: mac_b = {16'd0, dt_q[47:32]};
        endcase
        case (pass_q)
          2'd0:    addend = AccW'(prod_q);
          2'd1:    addend = AccW'(prod_q) << 16;
          default: addend = AccW'(prod_q) << 32;
        endcase
      end
      J_DEC: begin
        mac_a  = (AccelW + 1)'(decay_q);
        mac_b  = (pass_q == 2'd0) ? vabs_sel[31:0] : {24'd0, vabs_sel[VelW-1:32]};
        addend = (pass_q == 2'd0) ? AccW'(prod_q) : (AccW'(prod_q) << 32);
      end
      J_HSQ: begin
        mac_a = (pass_q == 2'd0) ? {1'b0, vabs_x[31:0]} : {1'b0, vabs_y[31:0]};
        mac_b = (pass_q == 2'd0) ? vabs_x[31:0] : vabs_y[31:0];
      end
      J_RCP: begin
        // passes: lo*lo, hi*lo, lo*hi, hi*hi
        pass_last = 2'd3;
        mac_a = pass_q[0] ? (AccelW + 1)'(num_q[NumW-1:RcpSplit])
                          : (AccelW + 1)'(num_q[RcpSplit-1:0]);
        mac_b = pass_q[1] ? 32'(RcpM[2*RcpSplit-1:RcpSplit]) : 32'(RcpM[RcpSplit-1:0]);
      end
      default: begin
        pass_last = 2'd2;
        case (pass_q)
          2'd0: begin
            mac_a = {1'b0, abs_acc(cx_q)};
            mac_b = abs_acc(cx_q);
          end
          2'd1: begin
            mac_a = {1'b0, abs_acc(cy_q)};
            mac_b = abs_acc(cy_q);
          end
          default: begin
            mac_a = {1'b0, abs_acc(cz_q)};
            mac_b = abs_acc(cz_q);
          end
        endcase
      end
    endcase
  end

  // velocity update after integration, clamped to 40 bits
  always_comb begin
    if (sum_sel[AccelW]) begin
      vs = {{3{vel_sel[VelW-1]}}, vel_sel} - {1'b0, quo_q};
    end else begin
      vs = {{3{vel_sel[VelW-1]}}, vel_sel} + {1'b0, quo_q};
    end
    if (vs[VelW+2:VelW-1] != '0 && vs[VelW+2:VelW-1] != '1) begin
      v_int = vs[VelW+2] ? {1'b1, {(VelW-1){1'b0}}} : {1'b0, {(VelW-1){1'b1}}};
    end else begin
      v_int = vs[VelW-1:0];
    end
  end

  // decayed velocity: |v| * factor >> frac, sign restored, clamped
  always_comb begin
    p_dec = acc_q[FracBits +: VelW + 1];
    if (vel_sel[VelW-1]) begin
      if (p_dec[VelW:VelW-1] != '0) v_dec = {1'b1, {(VelW-1){1'b0}}};
      else                          v_dec = -$signed(p_dec[VelW-1:0]);
    end else begin
      if (p_dec[VelW:VelW-1] != '0) v_dec = {1'b0, {(VelW-1){1'b1}}};
      else                          v_dec = p_dec[VelW-1:0];
    end
  end

  always_comb begin
    st_d        = st_q;
    axis_d      = axis_q;
    pass_d      = pass_q;
    job_d       = job_q;
    bias_x_d    = bias_x_q;
    bias_y_d    = bias_y_q;
    bias_z_d    = bias_z_q;
    deadband_d  = deadband_q;
    decay_d     = decay_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    cz_d        = cz_q;
    lx_d        = lx_q;
    ly_d        = ly_q;
    lz_d        = lz_q;
    last_time_d = last_time_q;
    dt_d        = dt_q;
    have_prev_d = have_prev_q;
    vx_d        = vx_q;
    vy_d        = vy_q;
    vz_d        = vz_q;
    max_h_d     = max_h_q;
    max_v_d     = max_v_q;
    max_a_d     = max_a_q;
    acc_d       = acc_q;
    prod_d      = prod_q;
    num_d       = num_q;
    quo_d       = quo_q;
    root_d      = root_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    sq_start    = 1'b0;

    if (out_valid_q && m_axis_tready_i) out_valid_d = 1'b0;

    if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgBiasX:    bias_x_d   = cfg_data_i;
        CfgBiasY:    bias_y_d   = cfg_data_i;
        CfgBiasZ:    bias_z_d   = cfg_data_i;
        CfgDeadband: deadband_d = cfg_data_i[DbW-1:0];
        CfgDecay:    decay_d    = cfg_data_i[DecayW-1:0];
        default: ;
      endcase
    end

    case (st_q)
      S_IDLE: begin
        if (accept) begin
          cx_d   = in_cx;
          cy_d   = in_cy;
          cz_d   = in_cz;
          dt_d   = in_t - last_time_q;
          last_time_d = in_t;
          axis_d = 2'd0;
          pass_d = 2'd0;
          acc_d  = '0;
          if (have_prev_q && (in_t > last_time_q)) begin
            st_d = S_AXIS;
          end else begin
            job_d = J_ASQ;
            st_d  = S_MUL;
          end
        end
      end
      S_AXIS: begin
        pass_d = 2'd0;
        acc_d  = '0;
        if (m_sel == '0) begin
          // zero trapezoid sum leaves this axis untouched
          if (axis_q == 2'd2) begin
            axis_d = 2'd0;
            job_d  = (cx_q == '0 && cy_q == '0) ? J_DEC : J_HSQ;
            st_d   = S_MUL;
          end else begin
            axis_d = axis_q + 2'd1;
          end
        end else begin
          job_d = J_INT;
          st_d  = S_MUL;
        end
      end
      S_MUL: begin
        prod_d = mac_a * {1'b0, mac_b};
        st_d   = S_ACC;
      end
      S_ACC: begin
        acc_d = acc_base + addend;
        if (pass_q == pass_last) begin
          case (job_q)
            J_INT:   st_d = S_DIV_INIT;
            J_DEC:   st_d = S_DEC_UPD;
            J_RCP:   st_d = S_DIV;
            default: st_d = S_SQ_START;
          endcase
        end else begin
          pass_d = pass_q + 2'd1;
          st_d   = S_MUL;
        end
      end
      S_DIV_INIT: begin
        // quotient would reach the cap: increment saturates the velocity anyway
        if (acc_q[AccW-1:IncW-1] >= (AccW - IncW + 1)'(UsTwice)) begin
          quo_d = IncW'(1) << (IncW - 1);
          st_d  = S_INT_UPD;
        end else begin
          num_d  = acc_q[UsShift +: NumW];
          pass_d = 2'd0;
          acc_d  = '0;
          job_d  = J_RCP;
          st_d   = S_MUL;
        end
      end
      S_DIV: begin
        quo_d = acc_q[RcpPost +: IncW];
        st_d  = S_INT_UPD;
      end
      S_INT_UPD: begin
        case (axis_q)
          2'd0:    vx_d = v_int;
          2'd1:    vy_d = v_int;
          default: vz_d = v_int;
        endcase
        pass_d = 2'd0;
        acc_d  = '0;
        if (axis_q == 2'd2) begin
          axis_d = 2'd0;
          job_d  = (cx_q == '0 && cy_q == '0) ? J_DEC : J_HSQ;
          st_d   = S_MUL;
        end else begin
          axis_d = axis_q + 2'd1;
          st_d   = S_AXIS;
        end
      end
      S_DEC_UPD: begin
        if (axis_q == 2'd0) vx_d = v_dec;
        else                vy_d = v_dec;
        pass_d = 2'd0;
        acc_d  = '0;
        st_d   = S_MUL;
        if (axis_q == 2'd0) begin
          axis_d = 2'd1;
        end else begin
          axis_d = 2'd0;
          job_d  = J_HSQ;
        end
      end
      S_SQ_START: begin
        if (job_q == J_HSQ && (hs_big || acc_q[RadW])) begin
          root_d = '1;
          st_d   = S_PEAK_HV;
        end else begin
          sq_start = 1'b1;
          st_d     = S_SQRT;
        end
      end
      S_SQRT: begin
        if (sq_done) begin
          root_d = sq_root;
          st_d   = (job_q == J_HSQ) ? S_PEAK_HV : S_DONE;
        end
      end
      S_PEAK_HV: begin
        if (root_q > max_h_q) max_h_d = root_q;
        if (vz_sat > max_v_q) max_v_d = vz_sat;
        job_d  = J_ASQ;
        pass_d = 2'd0;
        acc_d  = '0;
        st_d   = S_MUL;
      end
      S_DONE: begin
        if (!out_valid_q || m_axis_tready_i) begin
          if (root_q > max_a_q) max_a_d = root_q;
          lx_d        = cx_q;
          ly_d        = cy_q;
          lz_d        = cz_q;
          have_prev_d = 1'b1;
          out_valid_d = 1'b1;
          out_data_d  = {vz_q, vy_q, vx_q, max_a_d, max_v_q, max_h_q};
          st_d        = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      bias_x_q    <= '0;
      bias_y_q    <= '0;
      bias_z_q    <= '0;
      deadband_q  <= DeadbandRst;
      decay_q     <= DecayRst;
      lx_q        <= '0;
      ly_q        <= '0;
      lz_q        <= '0;
      last_time_q <= '0;
      have_prev_q <= 1'b0;
      vx_q        <= '0;
      vy_q        <= '0;
      vz_q        <= '0;
      max_h_q     <= '0;
      max_v_q     <= '0;
      max_a_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      bias_x_q    <= bias_x_d;
      bias_y_q    <= bias_y_d;
      bias_z_q    <= bias_z_d;
      deadband_q  <= deadband_d;
      decay_q     <= decay_d;
      lx_q        <= lx_d;
      ly_q        <= ly_d;
      lz_q        <= lz_d;
      last_time_q <= last_time_d;
      have_prev_q <= have_prev_d;
      vx_q        <= vx_d;
      vy_q        <= vy_d;
      vz_q        <= vz_d;
      max_h_q     <= max_h_d;
      max_v_q     <= max_v_d;
      max_a_q     <= max_a_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    axis_q     <= axis_d;
    pass_q     <= pass_d;
    job_q      <= job_d;
    cx_q       <= cx_d;
    cy_q       <= cy_d;
    cz_q       <= cz_d;
    dt_q       <= dt_d;
    acc_q      <= acc_d;
    prod_q     <= prod_d;
    num_q      <= num_d;
    quo_q      <= quo_d;
    root_q     <= root_d;
    out_data_q <= out_data_d;
  end

  ivpt_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start),
    .radicand_i (acc_q[RadW-1:0]),
    .done_o     (sq_done),
    .root_o     (sq_root)
  );

endmodule

// ===== src/ivpt_chk.sv =====
// Port-level checker for the IMU velocity peak tracker, bound to the top level.
// Depends on ivpt_pkg and imu_velocity_peak_tracker_assert.svh.
`include "imu_velocity_peak_tracker_assert.svh"

module ivpt_chk import ivpt_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            s_axis_tvalid_i,
  input logic            s_axis_tready_o,
  input logic [InW-1:0]  s_axis_tdata_i,
  input logic            m_axis_tvalid_o,
  input logic            m_axis_tready_i,
  input logic [OutW-1:0] m_axis_tdata_o,
  input logic            cfg_valid_i,
  input logic            cfg_ready_o,
  input cfg_idx_t        cfg_index_i,
  input logic [31:0]     cfg_data_i
);

  logic [VelW-1:0]  vz_abs;
  logic [RootW-1:0] vz_sat, peak_v;
  logic             in_req, cfg_req;

  assign vz_abs  = abs_vel(m_axis_tdata_o[OutW-1 -: VelW]);
  assign vz_sat  = (vz_abs[VelW-1:RootW] != '0) ? '1 : vz_abs[RootW-1:0];
  assign peak_v  = m_axis_tdata_o[2*RootW-1:RootW];
  assign in_req  = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_req = cfg_valid_i && cfg_ready_o && (cfg_index_i == CfgBiasX) && (cfg_data_i == '0);

  `IVPT_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o)
  `IVPT_ASSERT_NEXT(a_out_stable, m_axis_tvalid_o && !m_axis_tready_i, $stable(m_axis_tdata_o))
  `IVPT_ASSERT_NEXT(a_busy_after_req, in_req || (in_req && cfg_req), !s_axis_tready_o)
  `IVPT_ASSERT_SAME(a_vpeak_covers_vz, m_axis_tvalid_o && !$isunknown(s_axis_tdata_i[0]) || m_axis_tvalid_o, peak_v >= vz_sat)

endmodule

bind imu_velocity_peak_tracker ivpt_chk u_ivpt_chk (.*);
